>>> design/bfsk_pkg.sv
package bfsk_pkg;

    // Default build-time sizes.
    localparam int unsigned LUT_PHASE_BITS_DEF = 10;
    localparam int unsigned SAMPLE_BITS_DEF    = 16;
    localparam int unsigned MAX_SAMPLE_BITS    = 24;

    // Phase accumulator and register widths, and the request queue depth.
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register reset values and limits.
    localparam logic [PHASE_W-1:0] MIN_SYM_INC     = 32'd67108864;
    localparam logic [PHASE_W-1:0] SPACE_INC_RESET = 32'd419188808;
    localparam logic [PHASE_W-1:0] MARK_INC_RESET  = 32'd439804651;

    // Fixed-point constants for the sine table build.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYMBOL_INC = 2'd0,
        CFG_SPACE_INC  = 2'd1,
        CFG_MARK_INC   = 2'd2
    } cfg_index_t;

    // One queued request: the carrier step picked by the bit and the frame-end mark.
    typedef struct packed {
        logic [PHASE_W-1:0] inc;
        logic               last;
    } bit_req_t;

    // Per-sample status flags.
    typedef struct packed {
        logic symbol_done;
        logic frame_done;
    } sample_flags_t;

    // Quarter-wave sine entry r, evaluated by a Q30 Taylor series at elaboration.
    function automatic logic [MAX_SAMPLE_BITS-1:0] sine_point(
        input int unsigned r,
        input int unsigned lut_bits,
        input int unsigned sample_bits
    );
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        ampl;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        ampl = (64'd1 << (sample_bits - 1)) - 64'd1;
        x    = ((64'(r) * HALF_PI_Q30) + ((64'd1 << (lut_bits - 2)) >> 1)) >> (lut_bits - 2);
        x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
        sum  = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        v = (sum * $signed(ampl) + $signed(ONE_Q30 >> 1)) >>> 30;
        if (v > $signed(ampl)) begin
            v = $signed(ampl);
        end
        return v[MAX_SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> design/binary_fsk_nco_modulator_top.sv
// A bit request passes the request queue, stage 1, stage 2 and the output register to its first sample.
// Throughput: one sample per cycle unless m_ready stalls the output; a bit has 1 to 64
// samples, set by how often the symbol phase accumulator wraps.
// A two-entry request queue lets new bits be accepted while samples are still streaming.
// Reset (synchronous, active low) clears both phases, the queue and all valid flags,
// and loads the register defaults; it takes effect at once with no clearing pass.
module binary_fsk_nco_modulator_top #(
    parameter int unsigned LUT_PHASE_BITS = bfsk_pkg::LUT_PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS    = bfsk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_data_bit,
    input  logic                               s_frame_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_i_sample,
    output logic signed [SAMPLE_BITS-1:0]      m_q_sample,
    output logic                               m_symbol_done,
    output logic                               m_frame_done,
    input  logic                               cfg_wr_en,
    input  logic [bfsk_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bfsk_pkg::PHASE_W-1:0]       cfg_wdata
);
    import bfsk_pkg::*;

    logic               push;
    bit_req_t           push_req;
    logic               queue_full;
    logic               pop;
    logic               pop_valid;
    bit_req_t           pop_req;
    logic [PHASE_W-1:0] sym_inc;

    // Front: configuration registers and request intake.
    bfsk_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_bit  (s_data_bit),
        .s_frame_end (s_frame_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .push_req    (push_req),
        .queue_full  (queue_full),
        .sym_inc     (sym_inc)
    );

    // Request queue between intake and sample generation.
    bfsk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_req  (push_req),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_req   (pop_req)
    );

    // Back: oscillator, sine table and output register.
    bfsk_back #(
        .LUT_PHASE_BITS (LUT_PHASE_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .sym_inc       (sym_inc),
        .q_valid       (pop_valid),
        .q_req         (pop_req),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_i_sample    (m_i_sample),
        .m_q_sample    (m_q_sample),
        .m_symbol_done (m_symbol_done),
        .m_frame_done  (m_frame_done)
    );

endmodule

>>> design/bfsk_front.sv
module bfsk_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_data_bit,
    input  logic                                 s_frame_end,
    input  logic                                 cfg_wr_en,
    input  logic [bfsk_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bfsk_pkg::PHASE_W-1:0]         cfg_wdata,
    output logic                                 push,
    output bfsk_pkg::bit_req_t                   push_req,
    input  logic                                 queue_full,
    output logic [bfsk_pkg::PHASE_W-1:0]         sym_inc
);
    import bfsk_pkg::*;

    logic [PHASE_W-1:0] sym_inc_reg;
    logic [PHASE_W-1:0] space_inc_reg;
    logic [PHASE_W-1:0] mark_inc_reg;

    // Configuration register file; an index past the last register is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_inc_reg   <= MIN_SYM_INC;
            space_inc_reg <= SPACE_INC_RESET;
            mark_inc_reg  <= MARK_INC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SYMBOL_INC: sym_inc_reg   <= cfg_wdata;
                CFG_SPACE_INC:  space_inc_reg <= cfg_wdata;
                CFG_MARK_INC:   mark_inc_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A symbol step below the minimum is raised to it, which bounds a bit to 64 samples.
    assign sym_inc = (sym_inc_reg < MIN_SYM_INC) ? MIN_SYM_INC : sym_inc_reg;

    // Accept a request whenever the queue has room and turn the bit into a carrier step.
    assign s_ready       = !queue_full;
    assign push          = s_valid && !queue_full;
    assign push_req.inc  = s_data_bit ? mark_inc_reg : space_inc_reg;
    assign push_req.last = s_frame_end;

endmodule

>>> design/bfsk_queue.sv
module bfsk_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  bfsk_pkg::bit_req_t push_req,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output bfsk_pkg::bit_req_t pop_req
);
    import bfsk_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    bit_req_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_req   = mem_reg[rd_ptr_reg];

    // Request storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/bfsk_back.sv
module bfsk_back #(
    parameter int unsigned LUT_PHASE_BITS = bfsk_pkg::LUT_PHASE_BITS_DEF,
    parameter int unsigned SAMPLE_BITS    = bfsk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bfsk_pkg::PHASE_W-1:0]  sym_inc,
    input  logic                          q_valid,
    input  bfsk_pkg::bit_req_t            q_req,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_i_sample,
    output logic signed [SAMPLE_BITS-1:0] m_q_sample,
    output logic                          m_symbol_done,
    output logic                          m_frame_done
);
    import bfsk_pkg::*;

    localparam int unsigned L       = LUT_PHASE_BITS;
    localparam int unsigned QUARTER = 1 << (L - 2);
    localparam int unsigned MAG_W   = SAMPLE_BITS - 1;
    localparam int unsigned ADDR_W  = L - 1;

    // Quarter-wave sine ROM, built at elaboration.
    logic [MAG_W-1:0] rom_tbl [QUARTER+1];

    for (genvar r = 0; r <= QUARTER; r++) begin : g_rom
        localparam logic [MAX_SAMPLE_BITS-1:0] POINT = sine_point(r, L, SAMPLE_BITS);
        assign rom_tbl[r] = POINT[MAG_W-1:0];
    end

    // Sequencer state.
    logic               active_reg;
    logic               active_next;
    bit_req_t           held_reg;
    bit_req_t           cur_req;
    logic [PHASE_W-1:0] carrier_reg;
    logic [PHASE_W-1:0] carrier_next;
    logic [PHASE_W-1:0] symbol_reg;
    logic [PHASE_W-1:0] symbol_next;
    logic               wrapped;
    logic               advance;
    logic               gen;

    // Stage 1: table indexes and flags.
    logic          s1_valid_reg;
    logic [L-1:0]  s1_sin_idx_reg;
    logic [L-1:0]  s1_cos_idx_reg;
    sample_flags_t s1_flags_reg;

    // Stage 2: magnitudes and signs.
    logic             s2_valid_reg;
    logic [MAG_W-1:0] s2_sin_mag_reg;
    logic [MAG_W-1:0] s2_cos_mag_reg;
    logic             s2_sin_neg_reg;
    logic             s2_cos_neg_reg;
    sample_flags_t    s2_flags_reg;

    logic [ADDR_W-1:0] sin_addr;
    logic [ADDR_W-1:0] cos_addr;

    // Output register.
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_i_reg;
    logic signed [SAMPLE_BITS-1:0] m_q_reg;
    sample_flags_t                 m_flags_reg;

    // The whole sample pipeline moves together when the output slot is free.
    assign advance = !m_valid_reg || m_ready;
    assign gen     = advance && (active_reg || q_valid);
    assign pop     = gen && !active_reg;
    assign cur_req = active_reg ? held_reg : q_req;

    // Phase accumulators; the bit ends on the sample where the symbol phase wraps.
    always_comb begin
        carrier_next           = carrier_reg + cur_req.inc;
        {wrapped, symbol_next} = {1'b0, symbol_reg} + {1'b0, sym_inc};
        active_next            = !wrapped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            carrier_reg <= '0;
            symbol_reg  <= '0;
        end else if (gen) begin
            active_reg  <= active_next;
            carrier_reg <= carrier_next;
            symbol_reg  <= symbol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (gen) begin
            held_reg <= cur_req;
        end
    end

    // Stage 1 registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= gen;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_sin_idx_reg           <= carrier_next[PHASE_W-1 -: L];
            s1_cos_idx_reg           <= carrier_next[PHASE_W-1 -: L] + L'(QUARTER);
            s1_flags_reg.symbol_done <= wrapped;
            s1_flags_reg.frame_done  <= wrapped && cur_req.last;
        end
    end

    // Quadrant folding: odd quadrants read the table mirrored.
    always_comb begin
        if (s1_sin_idx_reg[L-2]) begin
            sin_addr = ADDR_W'(QUARTER) - {1'b0, s1_sin_idx_reg[L-3:0]};
        end else begin
            sin_addr = {1'b0, s1_sin_idx_reg[L-3:0]};
        end
        if (s1_cos_idx_reg[L-2]) begin
            cos_addr = ADDR_W'(QUARTER) - {1'b0, s1_cos_idx_reg[L-3:0]};
        end else begin
            cos_addr = {1'b0, s1_cos_idx_reg[L-3:0]};
        end
    end

    // Stage 2 registers: registered table reads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_sin_mag_reg <= rom_tbl[sin_addr];
            s2_cos_mag_reg <= rom_tbl[cos_addr];
            s2_sin_neg_reg <= s1_sin_idx_reg[L-1];
            s2_cos_neg_reg <= s1_cos_idx_reg[L-1];
            s2_flags_reg   <= s1_flags_reg;
        end
    end

    // Output register: the lower half-wave is negated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_i_reg     <= s2_cos_neg_reg ? -$signed({1'b0, s2_cos_mag_reg})
                                          :  $signed({1'b0, s2_cos_mag_reg});
            m_q_reg     <= s2_sin_neg_reg ? -$signed({1'b0, s2_sin_mag_reg})
                                          :  $signed({1'b0, s2_sin_mag_reg});
            m_flags_reg <= s2_flags_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_i_sample    = m_i_reg;
    assign m_q_sample    = m_q_reg;
    assign m_symbol_done = m_flags_reg.symbol_done;
    assign m_frame_done  = m_flags_reg.frame_done;

endmodule

>>> design/bfsk_checker.sv
module bfsk_checker #(
    parameter int unsigned SAMPLE_BITS = bfsk_pkg::SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_i_sample,
    input logic signed [SAMPLE_BITS-1:0] m_q_sample,
    input logic                          m_symbol_done,
    input logic                          m_frame_done
);
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled sample holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_i_sample) && $stable(m_q_sample)
            && $stable(m_symbol_done) && $stable(m_frame_done))
        else $error("stalled output sample changed");

    // The frame only ends on the last sample of a bit.
    a_frame_on_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_frame_done || m_symbol_done)
        else $error("frame done without symbol done");

    // The amplitude is symmetric, so the most negative code never appears.
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_i_sample != MOST_NEG && m_q_sample != MOST_NEG)
        else $error("sample outside the scaled range");

    // No sample is shown straight out of reset.
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("output valid right after reset");

endmodule

bind binary_fsk_nco_modulator_top bfsk_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bfsk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_i_sample    (m_i_sample),
    .m_q_sample    (m_q_sample),
    .m_symbol_done (m_symbol_done),
    .m_frame_done  (m_frame_done)
);
